// ===== rtl/tpt_pkg.sv =====
// Shared types and constants for the tag presence timeout tracker.
// Holds controller states, command and status structs and register map.
// No dependencies.
`default_nettype none

package tpt_pkg;

   localparam int NumTags    = 3;
   localparam int CountWidth = 16;
   localparam int IdWidth    = 16;
   localparam int AddrWidth  = 5;
   localparam int DataWidth  = 32;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // register byte addresses
   localparam logic [AddrWidth-1:0] ADDR_TAG0_ID      = 5'h00;
   localparam logic [AddrWidth-1:0] ADDR_TAG1_ID      = 5'h04;
   localparam logic [AddrWidth-1:0] ADDR_TAG2_ID      = 5'h08;
   localparam logic [AddrWidth-1:0] ADDR_TIMEOUT      = 5'h0c;
   localparam logic [AddrWidth-1:0] ADDR_AGE_PERIOD   = 5'h10;
   localparam logic [AddrWidth-1:0] ADDR_REPORT_PERIOD = 5'h14;

   // reset values, element 0 is tag 0
   localparam logic [NumTags-1:0][IdWidth-1:0] TagIdReset =
      {16'd2370, 16'd57501, 16'd37683};
   localparam logic [CountWidth-1:0] TimeoutReset      = 16'd4;
   localparam logic [CountWidth-1:0] AgePeriodReset    = 16'd1000;
   localparam logic [CountWidth-1:0] ReportPeriodReset = 16'd5000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BYTE,
      ST_AGE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic capture;
      logic take_byte;
      logic age_step;
      logic report_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic report_due;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/tpt_ctrl.sv =====
// Controller for the tag presence timeout tracker.
// Sequences byte and tick requests and owns the result valid flag.
// Depends on tpt_pkg.
`default_nettype none

module tpt_ctrl
   import tpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_type,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_type ? ST_AGE : ST_BYTE;
            end
         end
         ST_BYTE: begin
            cmd.take_byte = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_AGE: begin
            cmd.age_step = 1'b1;
            state_in     = ST_REPORT;
         end
         ST_REPORT: begin
            if (!status.report_due) begin
               cmd.report_step = 1'b1;
               state_in        = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // output register free: load the report
               cmd.report_step = 1'b1;
               cmd.load_out    = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/tpt_datapath.sv =====
// Datapath for the tag presence timeout tracker: configuration registers,
// byte pairing, silence counters, period counters and the result register.
// Depends on tpt_pkg.
`default_nettype none

module tpt_datapath
   import tpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output status_type                status,
   input  wire logic [7:0]           req_rx_byte,
   output logic [NumTags-1:0]        rsp_present_mask,
   input  wire logic                 cfg_write,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0]      prdata
);

   logic [NumTags-1:0][IdWidth-1:0]    tag_id_ff, tag_id_in;
   logic [CountWidth-1:0]              timeout_ff, timeout_in;
   logic [CountWidth-1:0]              age_period_ff, age_period_in;
   logic [CountWidth-1:0]              report_period_ff, report_period_in;

   logic                               pair_pending_ff, pair_pending_in;
   logic [NumTags-1:0][CountWidth-1:0] silent_ff, silent_in;
   logic [NumTags-1:0]                 present_ff, present_in;
   logic [CountWidth-1:0]              age_count_ff, age_count_in;
   logic [CountWidth-1:0]              report_count_ff, report_count_in;

   logic [7:0]                         first_byte_ff, first_byte_in;
   logic [7:0]                         byte_ff, byte_in;
   logic [NumTags-1:0]                 mask_ff, mask_in;

   logic [IdWidth-1:0]                 pair_id;
   logic [CountWidth:0]                age_next;
   logic [CountWidth:0]                report_next;
   logic [CountWidth-1:0]              silent_inc;

   logic [CountWidth-1:0]              wdata;

   assign wdata       = pwdata[CountWidth-1:0];
   assign pair_id     = {first_byte_ff, byte_ff};
   assign age_next    = {1'b0, age_count_ff} + {{CountWidth{1'b0}}, 1'b1};
   assign report_next = {1'b0, report_count_ff} + {{CountWidth{1'b0}}, 1'b1};

   assign status.report_due = report_next >= {1'b0, report_period_ff};

   // configuration writes
   always_comb begin
      tag_id_in        = tag_id_ff;
      timeout_in       = timeout_ff;
      age_period_in    = age_period_ff;
      report_period_in = report_period_ff;
      if (cfg_write) begin
         case (paddr)
            ADDR_TAG0_ID:       tag_id_in[0]     = wdata;
            ADDR_TAG1_ID:       tag_id_in[1]     = wdata;
            ADDR_TAG2_ID:       tag_id_in[2]     = wdata;
            ADDR_TIMEOUT:       timeout_in       = wdata;
            ADDR_AGE_PERIOD:    age_period_in    = wdata;
            ADDR_REPORT_PERIOD: report_period_in = wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         ADDR_TAG0_ID:       prdata = {{(DataWidth-IdWidth){1'b0}}, tag_id_ff[0]};
         ADDR_TAG1_ID:       prdata = {{(DataWidth-IdWidth){1'b0}}, tag_id_ff[1]};
         ADDR_TAG2_ID:       prdata = {{(DataWidth-IdWidth){1'b0}}, tag_id_ff[2]};
         ADDR_TIMEOUT:       prdata = {{(DataWidth-CountWidth){1'b0}}, timeout_ff};
         ADDR_AGE_PERIOD:    prdata = {{(DataWidth-CountWidth){1'b0}}, age_period_ff};
         ADDR_REPORT_PERIOD: prdata = {{(DataWidth-CountWidth){1'b0}}, report_period_ff};
         default:            prdata = '0;
      endcase
   end

   // request processing
   always_comb begin
      pair_pending_in = pair_pending_ff;
      silent_in       = silent_ff;
      present_in      = present_ff;
      age_count_in    = age_count_ff;
      report_count_in = report_count_ff;
      first_byte_in   = first_byte_ff;
      byte_in         = byte_ff;
      mask_in         = mask_ff;
      silent_inc      = '0;

      if (cmd.capture) begin
         byte_in = req_rx_byte;
      end

      if (cmd.take_byte) begin
         if (!pair_pending_ff) begin
            first_byte_in   = byte_ff;
            pair_pending_in = 1'b1;
         end else begin
            pair_pending_in = 1'b0;
            for (int i = 0; i < NumTags; i++) begin
               if (tag_id_ff[i] == pair_id) begin
                  silent_in[i]  = '0;
                  present_in[i] = 1'b1;
               end
            end
         end
      end

      if (cmd.age_step) begin
         if (age_next >= {1'b0, age_period_ff}) begin
            age_count_in = '0;
            // saturate the silence counters, then drop timed-out tags
            for (int i = 0; i < NumTags; i++) begin
               silent_inc = (silent_ff[i] == CountMax) ? silent_ff[i]
                                                       : silent_ff[i] + 1'b1;
               silent_in[i] = silent_inc;
               if (present_ff[i] && silent_inc >= timeout_ff) begin
                  present_in[i] = 1'b0;
               end
            end
         end else begin
            age_count_in = age_next[CountWidth-1:0];
         end
      end

      if (cmd.report_step) begin
         report_count_in = status.report_due ? '0 : report_next[CountWidth-1:0];
      end

      if (cmd.load_out) begin
         mask_in = present_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_id_ff        <= TagIdReset;
         timeout_ff       <= TimeoutReset;
         age_period_ff    <= AgePeriodReset;
         report_period_ff <= ReportPeriodReset;
         pair_pending_ff  <= 1'b0;
         first_byte_ff    <= '0;
         silent_ff        <= '0;
         present_ff       <= '0;
         age_count_ff     <= '0;
         report_count_ff  <= '0;
      end else begin
         tag_id_ff        <= tag_id_in;
         timeout_ff       <= timeout_in;
         age_period_ff    <= age_period_in;
         report_period_ff <= report_period_in;
         pair_pending_ff  <= pair_pending_in;
         first_byte_ff    <= first_byte_in;
         silent_ff        <= silent_in;
         present_ff       <= present_in;
         age_count_ff     <= age_count_in;
         report_count_ff  <= report_count_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      mask_ff <= mask_in;
   end

   assign rsp_present_mask = mask_ff;

endmodule

`default_nettype wire

// ===== rtl/tag_presence_timeout_tracker_unit.sv =====
// Tag presence timeout tracker: watches reader bytes and millisecond ticks
// and reports which of three configured tags were seen lately. A byte request
// is accepted, then paired and ID-matched; a tick request is accepted, then
// takes an ageing step and a report step, where a due report waits while an
// earlier one is held in the output register. The controller handles one
// request at a time; the output register lets the next request be accepted
// while a report waits to be taken. No clearing pass after reset.
// Depends on tpt_pkg, tpt_ctrl and tpt_datapath.
`default_nettype none

module tag_presence_timeout_tracker_unit
   import tpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_type,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [NumTags-1:0]        rsp_present_mask,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0]      prdata,
   output logic                      pready
);

   cmd_type    cmd;
   status_type status;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   tpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_rx_byte      (req_rx_byte),
      .rsp_present_mask (rsp_present_mask),
      .cfg_write        (cfg_write),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata)
   );

`ifndef NO_ASSERTIONS
   // a byte request never raises a report
   a_byte_no_report: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_type) |=> !$rose(rsp_valid))
      else $error("report raised by a byte request");

   // never overwrite a report that has not been taken
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("report register overwritten");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for tag_presence_timeout_tracker_unit: random and directed reader
// bytes and ticks, checked against an in-bench presence predictor.
// Depends on tpt_pkg and the RTL of the tracker.
`default_nettype none

module tb
   import tpt_pkg::*;
();

   localparam bit KIND_BYTE = 1'b0;
   localparam bit KIND_TICK = 1'b1;
   localparam int LongHoldCycles = 300;
   localparam int SettleCycles   = 10;
   localparam int TargetRequests = 1550;
   localparam int QuietFrom      = 1350;

   // Presence predictor and the queue of masks it expects to see reported.
   class presence_scoreboard;
      logic [IdWidth-1:0]    tag_id [NumTags];
      logic [CountWidth-1:0] timeout_steps;
      logic [CountWidth-1:0] age_period;
      logic [CountWidth-1:0] report_period;
      bit                    pair_pending;
      logic [7:0]            high_byte;
      logic [CountWidth-1:0] silent [NumTags];
      bit [NumTags-1:0]      present;
      logic [CountWidth-1:0] age_count;
      logic [CountWidth-1:0] report_count;
      logic [NumTags-1:0]    expected_masks [$];
      int                    fails;

      function new();
         for (int i = 0; i < NumTags; i++) begin
            tag_id[i] = TagIdReset[i];
            silent[i] = '0;
         end
         timeout_steps = TimeoutReset;
         age_period    = AgePeriodReset;
         report_period = ReportPeriodReset;
         pair_pending  = 1'b0;
         high_byte     = '0;
         present       = '0;
         age_count     = '0;
         report_count  = '0;
         fails         = 0;
      endfunction

      function void set_register(logic [AddrWidth-1:0] addr, logic [CountWidth-1:0] value);
         case (addr)
            ADDR_TAG0_ID:       tag_id[0] = value;
            ADDR_TAG1_ID:       tag_id[1] = value;
            ADDR_TAG2_ID:       tag_id[2] = value;
            ADDR_TIMEOUT:       timeout_steps = value;
            ADDR_AGE_PERIOD:    age_period = value;
            ADDR_REPORT_PERIOD: report_period = value;
            default: ;
         endcase
      endfunction

      function void note_request(bit kind, logic [7:0] value);
         logic [CountWidth:0]  next;
         logic [IdWidth-1:0]   id;
         if (kind == KIND_BYTE) begin
            if (!pair_pending) begin
               high_byte    = value;
               pair_pending = 1'b1;
            end else begin
               pair_pending = 1'b0;
               id = {high_byte, value};
               for (int i = 0; i < NumTags; i++)
                  if (tag_id[i] == id) begin
                     silent[i]  = '0;
                     present[i] = 1'b1;
                  end
            end
            return;
         end
         // ageing comes first, so a report on the same tick sees its effect
         next = {1'b0, age_count} + 1'b1;
         if (next >= {1'b0, age_period}) begin
            age_count = '0;
            for (int i = 0; i < NumTags; i++) begin
               if (silent[i] != CountMax)
                  silent[i] = silent[i] + 1'b1;
               if (present[i] && silent[i] >= timeout_steps)
                  present[i] = 1'b0;
            end
         end else begin
            age_count = next[CountWidth-1:0];
         end
         next = {1'b0, report_count} + 1'b1;
         if (next >= {1'b0, report_period}) begin
            report_count = '0;
            expected_masks.push_back(present);
         end else begin
            report_count = next[CountWidth-1:0];
         end
      endfunction

      function int pending();
         return expected_masks.size();
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         fails++;
      endtask

      task check_response(logic [NumTags-1:0] mask);
         logic [NumTags-1:0] want;
         if (expected_masks.size() == 0) begin
            report($sformatf("report with mask %b when none was due", mask));
            return;
         end
         want = expected_masks.pop_front();
         if (mask !== want)
            report($sformatf("present_mask %b, expected %b", mask, want));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_type = 1'b0;
   logic [7:0]           req_rx_byte = '0;
   logic                 rsp_ready = 1'b0;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire [NumTags-1:0]    rsp_present_mask;
   wire [DataWidth-1:0]  prdata;
   wire                  pready;

   presence_scoreboard sb = new();
   int requests_sent = 0;
   bit idling_on = 1'b1;
   bit quiet = 1'b0;
   int hold_asked = 0;

   tag_presence_timeout_tracker_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_present_mask (rsp_present_mask),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #(20 * 1000000);
      $display("tb: FAIL");
      $finish;
   end

   task automatic send_request(input bit kind, input logic [7:0] value);
      int gap;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, value);
      requests_sent++;
      if (idling_on && !quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_pair(input logic [IdWidth-1:0] id);
      send_request(KIND_BYTE, id[15:8]);
      send_request(KIND_BYTE, id[7:0]);
   endtask

   task automatic send_tick();
      send_request(KIND_TICK, 8'($urandom));
   endtask

   // hold the sender until every due report is out, then let the block settle
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [AddrWidth-1:0] addr,
                                 input logic [CountWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {{(DataWidth-CountWidth){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(addr, value);
   endtask

   task automatic set_config(input logic [IdWidth-1:0] id0, input logic [IdWidth-1:0] id1,
                             input logic [IdWidth-1:0] id2,
                             input logic [CountWidth-1:0] timeout_steps,
                             input logic [CountWidth-1:0] age_ticks,
                             input logic [CountWidth-1:0] report_ticks);
      drain_reports();
      write_register(ADDR_TAG0_ID, id0);
      write_register(ADDR_TAG1_ID, id1);
      write_register(ADDR_TAG2_ID, id2);
      write_register(ADDR_TIMEOUT, timeout_steps);
      write_register(ADDR_AGE_PERIOD, age_ticks);
      write_register(ADDR_REPORT_PERIOD, report_ticks);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [IdWidth-1:0] pick_id();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h1234;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_config(input int phase);
      logic [IdWidth-1:0]    id [NumTags];
      logic [CountWidth-1:0] timeout_steps;
      logic [CountWidth-1:0] age_ticks;
      logic [CountWidth-1:0] report_ticks;
      for (int i = 0; i < NumTags; i++)
         id[i] = pick_id();
      // share an ID now and then so duplicate matches come up
      if ($urandom_range(0, 3) == 0)
         id[$urandom_range(1, 2)] = id[0];
      case ($urandom_range(0, 9))
         0:       timeout_steps = 16'hFFFF;
         1:       timeout_steps = 16'd1;
         default: timeout_steps = 16'($urandom_range(1, 6));
      endcase
      age_ticks    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4));
      report_ticks = ($urandom_range(0, 11) == 0) ? 16'hFFFF : 16'($urandom_range(1, 10));
      if (phase == 2) begin
         age_ticks    = 16'd1;
         report_ticks = 16'd1;
      end
      set_config(id[0], id[1], id[2], timeout_steps, age_ticks, report_ticks);
   endtask

   // Ticks, mostly well-formed sightings of configured tags, some stray pairs
   // and lone bytes that shift the pairing.
   task automatic random_requests(input int count);
      logic [IdWidth-1:0] id;
      for (int n = 0; n < count; n++) begin
         if (requests_sent >= TargetRequests)
            break;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_tick();
            4, 5, 6, 7: begin
               id = sb.tag_id[$urandom_range(0, NumTags-1)];
               send_request(KIND_BYTE, id[15:8]);
               if ($urandom_range(0, 3) == 0) send_tick();
               send_request(KIND_BYTE, id[7:0]);
            end
            8: send_pair(16'($urandom));
            default: send_request(KIND_BYTE, 8'($urandom));
         endcase
      end
   endtask

   initial begin : stimulus
      int phase;
      int count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset IDs, then a tick that reports nothing under the reset periods
      send_pair(16'h9333);
      send_pair(16'hE09D);
      send_pair(16'h0942);
      send_tick();
      // duplicate IDs; a tick between the halves of a pair
      set_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
      send_request(KIND_BYTE, 8'h00);
      send_request(KIND_TICK, 8'hA5);
      send_request(KIND_BYTE, 8'h00);
      send_pair(16'hFFFF);
      send_tick();
      // zero timeout and zero periods
      set_config(16'h0000, 16'hFFFF, 16'h1234, 16'd0, 16'd0, 16'd0);
      send_pair(16'h1234);
      send_tick();
      send_pair(16'h0000);
      send_tick();
      // top of every range, then periods lowered to or below the running counts
      set_config(16'h8001, 16'h7FFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pair(16'h8001);
      send_tick();
      send_tick();
      set_config(16'h8001, 16'h7FFE, 16'hFFFF, 16'd2, 16'd1, 16'd2);
      send_tick();
      send_pair(16'h7FFE);
      send_tick();
      send_tick();

      phase = 0;
      while (requests_sent < TargetRequests) begin
         random_config(phase);
         idling_on = ($urandom_range(0, 3) != 0);
         if (requests_sent >= QuietFrom)
            quiet <= 1'b1;
         count = $urandom_range(40, 90);
         if (phase == 2) begin
            // stall the receiver long enough for the block to back up
            hold_asked <= hold_asked + 1;
            for (int n = 0; n < 40; n++) send_tick();
         end else if (phase == 5) begin
            random_requests(count / 2);
            drain_reports();
            random_requests(count / 2);
         end else begin
            random_requests(count);
         end
         phase++;
      end

      drain_reports();
      if (sb.fails == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin : rsp_side
      int stall;
      int hold;
      int hold_served;
      stall = 0;
      hold = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_present_mask);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold = LongHoldCycles;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idling_on && !quiet && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire
